FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Entry layout, cell control bundle, operation and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Capacity of the cell chain.
  localparam int unsigned MaxEntries = 64;
  // Width of a count that can hold 0..MaxEntries.
  localparam int unsigned CountW     = $clog2(MaxEntries + 1);

  // Fixed field widths.
  localparam int unsigned PriW   = 16;
  localparam int unsigned DataW  = 16;
  localparam int unsigned LimitW = 7;

  // Common width for comparing count against the limit.
  localparam int unsigned CmpW = (CountW > LimitW) ? CountW : LimitW;

  localparam logic [LimitW-1:0] EntryLimitReset = LimitW'(64);

  // Operation codes on the kind field.
  localparam logic KindInsert = 1'b0;
  localparam logic KindRemove = 1'b1;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StFull     = 2'd1,
    StRemoved  = 2'd2,
    StEmpty    = 2'd3
  } status_e;

  typedef struct packed {
    logic [PriW-1:0]  pri;    // two's complement
    logic [DataW-1:0] client;
    logic [DataW-1:0] delay;
  } entry_t;

  typedef struct packed {
    logic ins;  // shift right from the insert point
    logic rem;  // shift left, head leaves
  } cell_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on insert keeps, takes the new entry or takes the left
// neighbor's; on remove takes the right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,      // slot holds a live entry
  input  spq_pkg::entry_t     new_i,      // entry being inserted
  input  spq_pkg::entry_t     left_i,     // neighbor toward the head
  input  logic                left_ge_i,  // neighbor keeps its entry
  input  spq_pkg::entry_t     right_i,    // neighbor toward the tail
  output spq_pkg::entry_t     entry_o,
  output logic                ge_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // Live entry of greater or equal priority stays put (FIFO among equals).
  assign ge_o = occ_i && ($signed(new_i.pri) <= $signed(entry_q.pri));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (ge_o) begin
        entry_d = entry_q;
      end else if (left_ge_i) begin
        entry_d = new_i;
      end else begin
        entry_d = left_i;
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_i;
    end
  end

  // Payload only; occupancy lives in the fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue on a chain of sorting cells
// Entries stay in descending priority order; insert and remove both resolve
// by every cell comparing and shifting at once.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------
//   in       | input     | in_valid_i/in_ready_o  | kind, priority_req, client,
//            |           |                        | delay
//   out      | output    | out_valid_o/out_ready_i| status, out_priority,
//            |           |                        | out_client, out_delay, held
//   cfg      | input     | cfg_we_i (no wait)     | cfg_wdata_i -> entry_limit
//
// The cell chain updates at the accepting edge and the result sits in the
// output register from the next cycle on. Throughput is one beat per cycle
// while the output side keeps taking.
// Stalls: in_ready_o is high when the output register is empty or being
// drained in the same cycle; a result held while out_ready_i is low blocks
// the next request beat.
// Reset: count and output valid clear, entry_limit returns to 64 and the cell
// payloads clear to zero (slots past the count never reach the output).
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [spq_pkg::LimitW-1:0]         cfg_wdata_i,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic signed [spq_pkg::PriW-1:0]    priority_req_i,
  input  logic [spq_pkg::DataW-1:0]          client_i,
  input  logic [spq_pkg::DataW-1:0]          delay_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic signed [spq_pkg::PriW-1:0]    out_priority_o,
  output logic [spq_pkg::DataW-1:0]          out_client_o,
  output logic [spq_pkg::DataW-1:0]          out_delay_o,
  output logic [spq_pkg::CountW-1:0]         held_o
);

  localparam int unsigned N    = spq_pkg::MaxEntries;
  localparam int unsigned CntW = spq_pkg::CountW;
  localparam int unsigned CmpW = spq_pkg::CmpW;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  logic [spq_pkg::LimitW-1:0] limit_q;
  logic [CntW-1:0]            count_q, count_d;

  logic              out_valid_q;
  spq_pkg::status_e  status_q, status_d;
  spq_pkg::entry_t   res_q, res_d;
  logic [CntW-1:0]   held_q;

  logic accept;
  logic is_rem;
  logic full;
  logic empty;
  logic [CmpW-1:0] lim_eff;
  logic [CmpW-1:0] count_ext;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     new_entry;

  // Output register frees up when empty or taken this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_rem     = (kind_i == spq_pkg::KindRemove);

  // Effective limit: smaller of the register and the chain length.
  assign lim_eff   = (CmpW'(limit_q) < CmpW'(N)) ? CmpW'(limit_q) : CmpW'(N);
  assign count_ext = CmpW'(count_q);
  assign full      = (count_ext >= lim_eff);
  assign empty     = (count_q == '0);

  assign ctrl.ins = accept && !is_rem && !full;
  assign ctrl.rem = accept &&  is_rem && !empty;

  assign new_entry.pri    = priority_req_i;
  assign new_entry.client = client_i;
  assign new_entry.delay  = delay_i;

  // --------------------------------------------------------------------------
  // Cell chain: index 0 is the head
  // --------------------------------------------------------------------------
  spq_pkg::entry_t cell_q [N];
  logic [N-1:0]    ge;
  logic [N-1:0]    occ;

  for (genvar g = 0; g < N; g++) begin : g_cell
    spq_pkg::entry_t left_ent;
    spq_pkg::entry_t right_ent;
    logic            left_ge;

    assign occ[g] = (CntW'(g) < count_q);

    if (g == 0) begin : g_head
      // Nothing ahead of the head: it takes the new entry unless it stays.
      assign left_ent = new_entry;
      assign left_ge  = 1'b1;
    end else begin : g_body
      assign left_ent = cell_q[g-1];
      assign left_ge  = ge[g-1];
    end

    if (g == N - 1) begin : g_tail
      assign right_ent = cell_q[g];
    end else begin : g_mid
      assign right_ent = cell_q[g+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .occ_i     (occ[g]),
      .new_i     (new_entry),
      .left_i    (left_ent),
      .left_ge_i (left_ge),
      .right_i   (right_ent),
      .entry_o   (cell_q[g]),
      .ge_o      (ge[g])
    );
  end

  // --------------------------------------------------------------------------
  // Next count and result
  // --------------------------------------------------------------------------
  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    res_d    = '0;
    if (is_rem) begin
      if (empty) begin
        status_d = spq_pkg::StEmpty;
      end else begin
        status_d = spq_pkg::StRemoved;
        res_d    = cell_q[0];
        count_d  = count_q - CntW'(1);
      end
    end else begin
      if (full) begin
        status_d = spq_pkg::StFull;
      end else begin
        status_d = spq_pkg::StInserted;
        count_d  = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= spq_pkg::EntryLimitReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: loaded on accept, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      res_q    <= res_d;
      held_q   <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_priority_o = res_q.pri;
  assign out_client_o   = res_q.client;
  assign out_delay_o    = res_q.delay;
  assign held_o         = held_q;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sorted_priority_queue
// Drives insert and remove beats through the valid/ready request channel and
// checks every result beat against a shadow queue kept in the bench. Covers
// ordering and ties, empty and full responses, limit changes (zero, above
// capacity, below the held count), a long output stall and random traffic.
// ----------------------------------------------------------------------------
module tb_top;

  // Expected content of one result beat.
  typedef struct packed {
    spq_pkg::status_e                status;
    logic [spq_pkg::PriW-1:0]        pri;
    logic [spq_pkg::DataW-1:0]       client;
    logic [spq_pkg::DataW-1:0]       delay;
    logic [spq_pkg::CountW-1:0]      held;
  } queue_result_t;

  localparam int HoldOffCycles = 300;

  // DUT inputs, known from time zero.
  logic                             clk_i        = 1'b0;
  logic                             rst_ni       = 1'b0;
  logic                             cfg_we       = 1'b0;
  logic [spq_pkg::LimitW-1:0]       cfg_wdata    = '0;
  logic                             in_valid     = 1'b0;
  logic                             kind         = spq_pkg::KindInsert;
  logic signed [spq_pkg::PriW-1:0]  priority_req = '0;
  logic [spq_pkg::DataW-1:0]        client       = '0;
  logic [spq_pkg::DataW-1:0]        delay        = '0;
  logic                             out_ready    = 1'b0;

  // DUT outputs.
  logic                             in_ready;
  logic                             out_valid;
  logic [1:0]                       status;
  logic signed [spq_pkg::PriW-1:0]  out_priority;
  logic [spq_pkg::DataW-1:0]        out_client;
  logic [spq_pkg::DataW-1:0]        out_delay;
  logic [spq_pkg::CountW-1:0]       held;

  // Shadow copy of the queue state and its limit register.
  spq_pkg::entry_t         shadow_slots [spq_pkg::MaxEntries];
  int                      shadow_count = 0;
  int                      shadow_limit = int'(spq_pkg::EntryLimitReset);

  // Results predicted at acceptance, oldest first.
  queue_result_t           pending_results [$];
  int                      mismatches = 0;

  // Idle controls for the sender and the receiver, and the hold-off request.
  bit                      tx_idling    = 1'b1;
  bit                      rx_idling    = 1'b1;
  bit                      hold_off_req = 1'b0;

  sorted_priority_queue u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .priority_req_i (priority_req),
    .client_i       (client),
    .delay_i        (delay),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .out_priority_o (out_priority),
    .out_client_o   (out_client),
    .out_delay_o    (out_delay),
    .held_o         (held)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow queue: applies one operation and returns the result it must give.
  // Inserts go behind every entry of greater or equal priority (FIFO ties).
  // --------------------------------------------------------------------------
  function automatic queue_result_t predict_queue_op(input logic op,
      input logic signed [spq_pkg::PriW-1:0] pri,
      input logic [spq_pkg::DataW-1:0] cli,
      input logic [spq_pkg::DataW-1:0] dly);
    queue_result_t r;
    int room;
    int pos;
    int i;
    r.status = spq_pkg::StInserted;
    r.pri    = '0;
    r.client = '0;
    r.delay  = '0;
    // limit above capacity is clipped to the chain length
    room = (shadow_limit < int'(spq_pkg::MaxEntries)) ? shadow_limit
                                                      : int'(spq_pkg::MaxEntries);
    if (op == spq_pkg::KindInsert) begin
      if (shadow_count >= room) begin
        r.status = spq_pkg::StFull;
      end else begin
        pos = 0;
        while (pos < shadow_count && pri <= $signed(shadow_slots[pos].pri)) pos++;
        for (i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[pos].pri    = pri;
        shadow_slots[pos].client = cli;
        shadow_slots[pos].delay  = dly;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = spq_pkg::StEmpty;
    end else begin
      r.status = spq_pkg::StRemoved;
      r.pri    = shadow_slots[0].pri;
      r.client = shadow_slots[0].client;
      r.delay  = shadow_slots[0].delay;
      for (i = 0; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i+1];
      shadow_count--;
    end
    r.held = spq_pkg::CountW'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every accepted result beat is matched to the oldest
  // prediction. Outputs are registers, so values read here are pre-edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    queue_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", {30'd0, status}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", {30'd0, status}, {30'd0, want.status});
        if (out_priority !== want.pri)
          report_mismatch("out_priority", {16'd0, out_priority}, {16'd0, want.pri});
        if (out_client !== want.client)
          report_mismatch("out_client", {16'd0, out_client}, {16'd0, want.client});
        if (out_delay !== want.delay)
          report_mismatch("out_delay", {16'd0, out_delay}, {16'd0, want.delay});
        if (held !== want.held)
          report_mismatch("held", {25'd0, held}, {25'd0, want.held});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request, and a
  // steady ready once idling is switched off. One NBA per loop pass, and
  // every pass waits on the clock before the next.
  // --------------------------------------------------------------------------
  initial begin : receiver
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if (rx_idling && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Valid is left high after acceptance so back-to-back beats never
  // lower and raise it in one step; a gap or settle_queue drops it.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic op,
      input logic signed [spq_pkg::PriW-1:0] pri,
      input logic [spq_pkg::DataW-1:0] cli,
      input logic [spq_pkg::DataW-1:0] dly);
    if (tx_idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    kind         <= op;
    priority_req <= pri;
    client       <= cli;
    delay        <= dly;
    in_valid     <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    pending_results.push_back(predict_queue_op(op, pri, cli, dly));
  endtask

  // Mix of tie-prone small values, extremes and full-range priorities.
  function automatic logic signed [spq_pkg::PriW-1:0] rand_priority();
    int v;
    v = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 5))
      0, 1:    return v[spq_pkg::PriW-1:0];
      2:       return 16'h8000;
      3:       return 16'h7fff;
      default: return spq_pkg::PriW'($urandom());
    endcase
  endfunction

  task automatic send_random_beat(input int insert_pct);
    logic op;
    op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::KindInsert
                                              : spq_pkg::KindRemove;
    send_beat(op, rand_priority(), spq_pkg::DataW'($urandom()),
              spq_pkg::DataW'($urandom()));
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic settle_queue();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Only called with the queue settled.
  task automatic write_entry_limit(input logic [spq_pkg::LimitW-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    shadow_limit = int'(value);
    cfg_we    <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty remove, field extremes, equal priorities leaving in arrival order.
  task automatic test_order_and_ties();
    send_beat(spq_pkg::KindRemove, 16'sh7fff, 16'hffff, 16'hffff);
    send_beat(spq_pkg::KindInsert, 16'sh7fff, 16'hffff, 16'hffff);
    send_beat(spq_pkg::KindInsert, 16'sh8000, 16'h0000, 16'h0000);
    send_beat(spq_pkg::KindInsert, 16'sh0000, 16'h0001, 16'h0aaa);
    send_beat(spq_pkg::KindInsert, 16'sh0000, 16'h0002, 16'h5555);
    send_beat(spq_pkg::KindInsert, 16'sh0000, 16'h0003, 16'h1234);
    send_beat(spq_pkg::KindInsert, -16'sd1,   16'h8000, 16'h00ff);
    send_beat(spq_pkg::KindInsert, 16'sh0001, 16'h7fff, 16'hff00);
    repeat (8) send_beat(spq_pkg::KindRemove, 16'sh0000, 16'h0000, 16'h0000);
    settle_queue();
  endtask

  // Limit of one, of zero, and lowered below the held count.
  task automatic test_limit_corners();
    write_entry_limit(spq_pkg::LimitW'(1));
    send_beat(spq_pkg::KindInsert, 16'sd10, 16'h0010, 16'h0001);
    send_beat(spq_pkg::KindInsert, 16'sd20, 16'h0020, 16'h0002);
    settle_queue();
    write_entry_limit(spq_pkg::LimitW'(0));
    send_beat(spq_pkg::KindInsert, 16'sd30, 16'h0030, 16'h0003);
    send_beat(spq_pkg::KindRemove, 16'sd0,  16'h0000, 16'h0000);
    settle_queue();
    write_entry_limit(spq_pkg::LimitW'(64));
    repeat (3) send_random_beat(100);
    settle_queue();
    // three held against a limit of two: inserts refused until the count drops below two, removes still work
    write_entry_limit(spq_pkg::LimitW'(2));
    send_beat(spq_pkg::KindInsert, 16'sd5, 16'hbeef, 16'h0005);
    send_beat(spq_pkg::KindRemove, 16'sd0, 16'h0000, 16'h0000);
    send_beat(spq_pkg::KindInsert, 16'sd6, 16'hcafe, 16'h0006);
    send_beat(spq_pkg::KindRemove, 16'sd0, 16'h0000, 16'h0000);
    send_beat(spq_pkg::KindInsert, 16'sd7, 16'hf00d, 16'h0007);
    repeat (3) send_beat(spq_pkg::KindRemove, 16'sd0, 16'h0000, 16'h0000);
    settle_queue();
  endtask

  // Limit above capacity: the chain fills to its real size, then refuses.
  task automatic test_full_capacity();
    write_entry_limit(spq_pkg::LimitW'(127));
    repeat (int'(spq_pkg::MaxEntries) + 2) send_random_beat(100);
    repeat (int'(spq_pkg::MaxEntries) + 2) send_random_beat(0);
    settle_queue();
  endtask

  // Random traffic across several limits; the insert share swings so both
  // full and empty are reached. Held entries carry over between phases.
  task automatic test_random_traffic();
    logic [spq_pkg::LimitW-1:0] limits [8];
    int                         mix    [3];
    int                         p;
    limits = '{spq_pkg::LimitW'(64), spq_pkg::LimitW'(1), spq_pkg::LimitW'(3),
               spq_pkg::LimitW'(127), spq_pkg::LimitW'(16), spq_pkg::LimitW'(40),
               spq_pkg::LimitW'(64), spq_pkg::LimitW'(2)};
    mix = '{85, 25, 55};
    for (p = 0; p < 8; p++) begin
      write_entry_limit(limits[p]);
      repeat (80) send_random_beat(mix[p % 3]);
      settle_queue();
    end
  endtask

  // Long output hold-off while beats keep coming: input must stall.
  task automatic test_output_stall();
    write_entry_limit(spq_pkg::LimitW'(64));
    hold_off_req = 1'b1;
    repeat (40) send_random_beat(70);
    settle_queue();
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_full_rate();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    write_entry_limit(spq_pkg::LimitW'(20));
    repeat (150) send_random_beat(60);
    settle_queue();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_order_and_ties();
    test_limit_corners();
    test_full_capacity();
    test_random_traffic();
    test_output_stall();
    test_full_rate();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, far past the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
